### rtl/lhhw_pkg.sv
// ----------------------------------------------------------------------------
// lhhw_pkg
// Types and constants shared by the lock hold and heartbeat watchdog.
// ----------------------------------------------------------------------------
package lhhw_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = IDX_W + 1;

  localparam int BYTE_W = 48;
  localparam int TIME_W = 48;
  localparam int TMO_W  = 31;
  localparam int ID_W   = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [BYTE_W-1:0] WARN_RESET = 48'd536870912;
  localparam logic [BYTE_W-1:0] CRIT_RESET = 48'd1073741824;
  localparam logic [TMO_W-1:0]  LOCK_TMO_RESET = 31'd30000;
  localparam logic [TMO_W-1:0]  BEAT_TMO_RESET = 31'd30000;

  typedef enum logic [2:0] {
    OP_ACQUIRE   = 3'd0,
    OP_RELEASE   = 3'd1,
    OP_HEARTBEAT = 3'd2,
    OP_ALLOC     = 3'd3,
    OP_FREE      = 3'd4,
    OP_TICK      = 3'd5,
    OP_CHECK     = 3'd6
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WARN     = 3'd0,
    REG_CRIT     = 3'd1,
    REG_LOCK_TMO = 3'd2,
    REG_BEAT_TMO = 3'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    LVL_NONE = 2'd0,
    LVL_WARN = 2'd1,
    LVL_CRIT = 2'd2
  } level_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic [ID_W-1:0]   lock_id;
    logic [ID_W-1:0]   owner_id;
    logic [BYTE_W-1:0] byte_count;
  } cmd_t;

  typedef struct packed {
    logic              stuck_found;
    logic [ID_W-1:0]   stuck_lock;
    logic [ID_W-1:0]   stuck_owner;
    logic [TIME_W-1:0] held_time_ms;
    logic [1:0]        pressure_event;
    logic              heartbeat_stall;
    logic [TIME_W-1:0] heartbeat_age_ms;
    logic              table_full;
    logic [BYTE_W-1:0] usage_bytes;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]   lock;
    logic [ID_W-1:0]   owner;
    logic [TIME_W-1:0] since;
  } entry_t;

endpackage

### rtl/lock_hold_and_heartbeat_watchdog_top.sv
// ----------------------------------------------------------------------------
// lock_hold_and_heartbeat_watchdog_top
// Lock table, usage counter, pressure level and heartbeat monitor.
// ----------------------------------------------------------------------------
// Heartbeat, alloc, free, tick: result strobe in the cycle after start.
// Acquire and release: one pass over the lock table RAM, one entry per cycle;
// a match ends the pass early.
// Check: the same pass until the first stuck lock, then the ST_FIN state.
// For table operations busy stays high until the result; the result strobe cannot be stalled.
// rst (synchronous) clears valid bits and counters and loads the limit registers with their reset values.
module lock_hold_and_heartbeat_watchdog_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  lhhw_pkg::cmd_t                          cmd,
  output logic                                    busy,
  output logic                                    done,
  output lhhw_pkg::result_t                       result,
  input  logic                                    cfg_we,
  input  logic [lhhw_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [lhhw_pkg::CFG_DATA_W-1:0]         cfg_data
);

  import lhhw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t state;

  logic [BYTE_W-1:0] warn_limit;
  logic [BYTE_W-1:0] crit_limit;
  logic [TMO_W-1:0]  lock_timeout_ms;
  logic [TMO_W-1:0]  beat_timeout;

  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [TIME_W-1:0] time_now;
  logic [BYTE_W-1:0] usage_total;
  logic [1:0]        report_level;
  logic [TIME_W-1:0] beat_time;
  logic              beat_seen;

  cmd_t              cur;
  op_t               cur_op;
  logic [CNT_W-1:0]  rd_idx;
  logic              cmp_vld;
  logic [IDX_W-1:0]  cmp_idx;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;

  lhhw_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Entry compare on the data read in the previous cycle
  logic              ent_valid;
  logic              lock_match;
  logic [TIME_W-1:0] held;
  logic              stuck;
  logic              hit;
  logic              last_entry;
  logic              free_now;
  logic [IDX_W-1:0]  open_slot;

  always_comb begin
    ent_valid  = entry_valid[cmp_idx];
    lock_match = ent_valid && (ram_rdata.lock == cur.lock_id);
    held       = time_now - ram_rdata.since;
    stuck      = ent_valid && (held > {{(TIME_W-TMO_W){1'b0}}, lock_timeout_ms});
    case (cur_op) inside
      OP_ACQUIRE, OP_RELEASE: hit = cmp_vld && lock_match;
      OP_CHECK:               hit = cmp_vld && stuck;
      default:                hit = 1'b0;
    endcase
    last_entry = cmp_vld && (cmp_idx == IDX_W'(TABLE_ENTRIES - 1));
    free_now   = free_found || !ent_valid;
    open_slot  = free_found ? free_idx : cmp_idx;
  end

  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = cmp_idx;
    ram_wdata.lock  = cur.lock_id;
    ram_wdata.owner = cur.owner_id;
    ram_wdata.since = time_now;
    if (state == ST_SCAN && cur_op == OP_ACQUIRE) begin
      if (hit) begin
        ram_we = 1'b1;
      end else if (last_entry && free_now) begin
        ram_we    = 1'b1;
        ram_waddr = open_slot;
      end
    end
  end

  // Non-table operations
  logic [BYTE_W:0]   alloc_sum;
  logic [BYTE_W-1:0] alloc_usage;
  logic [BYTE_W-1:0] free_usage;
  logic [BYTE_W-1:0] idle_usage;

  always_comb begin
    alloc_sum   = {1'b0, usage_total} + {1'b0, cmd.byte_count};
    alloc_usage = alloc_sum[BYTE_W] ? {BYTE_W{1'b1}} : alloc_sum[BYTE_W-1:0];
    free_usage  = (cmd.byte_count >= usage_total) ? '0 : usage_total - cmd.byte_count;
    case (op_t'(cmd.operation))
      OP_ALLOC: idle_usage = alloc_usage;
      OP_FREE:  idle_usage = free_usage;
      default:  idle_usage = usage_total;
    endcase
  end

  // Result strobe for the cycle after this edge
  logic scan_op;
  logic finish;

  always_comb begin
    case (op_t'(cmd.operation)) inside
      OP_ACQUIRE, OP_RELEASE, OP_CHECK: scan_op = 1'b1;
      default:                          scan_op = 1'b0;
    endcase
    unique case (state)
      ST_IDLE: finish = start && !scan_op;
      ST_SCAN: finish = (hit || last_entry) && (cur_op != OP_CHECK);
      ST_FIN:  finish = 1'b1;
      default: finish = 1'b0;
    endcase
  end

  // Pressure level and heartbeat age for check
  level_t            level;
  logic [TIME_W-1:0] beat_age;

  always_comb begin
    if (usage_total >= crit_limit) begin
      level = LVL_CRIT;
    end else if (usage_total >= warn_limit) begin
      level = LVL_WARN;
    end else begin
      level = LVL_NONE;
    end
    beat_age = time_now - beat_time;
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      done            <= 1'b0;
      warn_limit      <= WARN_RESET;
      crit_limit      <= CRIT_RESET;
      lock_timeout_ms <= LOCK_TMO_RESET;
      beat_timeout    <= BEAT_TMO_RESET;
      entry_valid     <= '0;
      time_now        <= '0;
      usage_total     <= '0;
      report_level    <= LVL_NONE;
      beat_time       <= '0;
      beat_seen       <= 1'b0;
      rd_idx          <= '0;
      cmp_vld         <= 1'b0;
      free_found      <= 1'b0;
    end else begin
      done <= finish;

      if (cfg_we) begin
        case (cfg_index)
          REG_WARN:     warn_limit      <= cfg_data[BYTE_W-1:0];
          REG_CRIT:     crit_limit      <= cfg_data[BYTE_W-1:0];
          REG_LOCK_TMO: lock_timeout_ms <= cfg_data[TMO_W-1:0];
          REG_BEAT_TMO: beat_timeout    <= cfg_data[TMO_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cur        <= cmd;
            cur_op     <= op_t'(cmd.operation);
            rd_idx     <= '0;
            cmp_vld    <= 1'b0;
            free_found <= 1'b0;
            result     <= {{($bits(result_t)-BYTE_W){1'b0}}, idle_usage};
            case (op_t'(cmd.operation)) inside
              OP_ACQUIRE, OP_RELEASE, OP_CHECK: begin
                state <= ST_SCAN;
              end
              OP_HEARTBEAT: begin
                beat_time <= time_now;
                beat_seen <= 1'b1;
              end
              OP_ALLOC: begin
                usage_total <= alloc_usage;
              end
              OP_FREE: begin
                usage_total <= free_usage;
              end
              OP_TICK: begin
                time_now <= time_now + TIME_W'(1);
              end
              default: ;
            endcase
          end
        end

        ST_SCAN: begin
          // Issue the next read while comparing the previous entry
          if (rd_idx < CNT_W'(TABLE_ENTRIES) && !hit) begin
            rd_idx  <= rd_idx + CNT_W'(1);
            cmp_vld <= 1'b1;
            cmp_idx <= rd_idx[IDX_W-1:0];
          end else begin
            cmp_vld <= 1'b0;
          end

          if (cmp_vld && !ent_valid && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end

          if (hit) begin
            case (cur_op)
              OP_RELEASE: begin
                entry_valid[cmp_idx] <= 1'b0;
                result.usage_bytes   <= usage_total;
                state                <= ST_IDLE;
              end
              OP_CHECK: begin
                result.stuck_found  <= 1'b1;
                result.stuck_lock   <= ram_rdata.lock;
                result.stuck_owner  <= ram_rdata.owner;
                result.held_time_ms <= held;
                state               <= ST_FIN;
              end
              default: begin
                result.usage_bytes <= usage_total;
                state              <= ST_IDLE;
              end
            endcase
          end else if (last_entry) begin
            case (cur_op)
              OP_ACQUIRE: begin
                if (free_now) begin
                  entry_valid[open_slot] <= 1'b1;
                end else begin
                  result.table_full <= 1'b1;
                end
                result.usage_bytes <= usage_total;
                state              <= ST_IDLE;
              end
              OP_CHECK: begin
                state <= ST_FIN;
              end
              default: begin
                result.usage_bytes <= usage_total;
                state              <= ST_IDLE;
              end
            endcase
          end
        end

        ST_FIN: begin
          if (level != LVL_NONE && level != report_level) begin
            report_level          <= level;
            result.pressure_event <= level;
          end else if (level == LVL_NONE) begin
            // drop silently back to no pressure
            report_level <= LVL_NONE;
          end
          if (beat_seen) begin
            result.heartbeat_age_ms <= beat_age;
            result.heartbeat_stall  <=
              (beat_age > {{(TIME_W-TMO_W){1'b0}}, beat_timeout});
          end
          result.usage_bytes <= usage_total;
          state              <= ST_IDLE;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/lhhw_ram.sv
// ----------------------------------------------------------------------------
// lhhw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lhhw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
